>>> sv/rbsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbsi_pkg;

  localparam int unsigned DefCoordWidth = 32;
  localparam int unsigned DefFracBits   = 16;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned NumAxes       = 3;

  // Configuration register indexes.
  typedef enum logic [CfgIndexWidth-1:0] {
    CfgBoxMinX = 3'd0,
    CfgBoxMinY = 3'd1,
    CfgBoxMinZ = 3'd2,
    CfgBoxMaxX = 3'd3,
    CfgBoxMaxY = 3'd4,
    CfgBoxMaxZ = 3'd5
  } cfg_reg_e;

endpackage

`default_nettype wire

>>> sv/ray_box_slab_intersect.sv
`timescale 1ns / 1ps
`default_nettype none

// Ray against axis-aligned box slab test. The box is held in six configuration
// registers and resets to an empty box. The user must write these registers only
// while the block is idle; the block itself does not enforce it. One ray transfer is
// taken in every cycle while the input is not stalled. The six-stage pipeline is: slab
// differences, the six slab products, scaling and saturation, the x/y slab merge, the
// z slab merge, and the clamp to the ray interval. The products are the deepest stage.
// A stall on the output fills empty stages first and only then holds the input. When
// there is no hit, t_near and t_far are zero.
module ray_box_slab_intersect
  import rbsi_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = DefCoordWidth,
  parameter int unsigned FRAC_BITS   = DefFracBits
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,

  input  wire                          cfg_we_i,
  input  wire        [CfgIndexWidth-1:0] cfg_index_i,
  input  wire        [COORD_WIDTH-1:0] cfg_wdata_i,

  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire signed [COORD_WIDTH-1:0] origin_x_i,
  input  wire signed [COORD_WIDTH-1:0] origin_y_i,
  input  wire signed [COORD_WIDTH-1:0] origin_z_i,
  input  wire signed [COORD_WIDTH-1:0] inv_dir_x_i,
  input  wire signed [COORD_WIDTH-1:0] inv_dir_y_i,
  input  wire signed [COORD_WIDTH-1:0] inv_dir_z_i,
  input  wire signed [COORD_WIDTH-1:0] t_start_i,
  input  wire signed [COORD_WIDTH-1:0] t_end_i,

  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         hit_o,
  output logic signed [COORD_WIDTH-1:0] t_near_o,
  output logic signed [COORD_WIDTH-1:0] t_far_o
);

  localparam int unsigned W       = COORD_WIDTH;
  localparam int unsigned PW      = 2 * COORD_WIDTH + 1;
  localparam int unsigned NStages = 6;

  localparam logic signed [W-1:0] CoordMax  = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CoordMin  = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] CoordZero = '0;

  // ---------------------------------------------------------------------------
  // Box registers
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] box_min_q [NumAxes];
  logic signed [W-1:0] box_max_q [NumAxes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NumAxes; a++) begin
        box_min_q[a] <= CoordMax;
        box_max_q[a] <= CoordMin;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgBoxMinX: box_min_q[0] <= cfg_wdata_i;
        CfgBoxMinY: box_min_q[1] <= cfg_wdata_i;
        CfgBoxMinZ: box_min_q[2] <= cfg_wdata_i;
        CfgBoxMaxX: box_max_q[0] <= cfg_wdata_i;
        CfgBoxMaxY: box_max_q[1] <= cfg_wdata_i;
        CfgBoxMaxZ: box_max_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic [NStages-1:0] v_q;
  logic [NStages-1:0] rdy;
  logic [NStages-1:0] v_in;

  // A stage can load when it is empty or its contents move on this cycle.
  always_comb begin
    rdy[NStages-1] = !v_q[NStages-1] || !out_stall_i;
    for (int s = NStages - 2; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
  end

  assign v_in = {v_q[NStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NStages; s++) begin
        if (rdy[s]) begin
          v_q[s] <= v_in[s];
        end
      end
    end
  end

  logic [NStages-1:0] load;
  assign load       = rdy & v_in;
  assign in_stall_o = !rdy[0];

  logic signed [W-1:0] org [NumAxes];
  logic signed [W-1:0] kin [NumAxes];

  always_comb begin
    org[0] = origin_x_i;
    org[1] = origin_y_i;
    org[2] = origin_z_i;
    kin[0] = inv_dir_x_i;
    kin[1] = inv_dir_y_i;
    kin[2] = inv_dir_z_i;
  end

  // Ray interval travels alongside the slab lanes.
  logic signed [W-1:0] t0_q [4];
  logic signed [W-1:0] t1_q [4];

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      t0_q[0] <= t_start_i;
      t1_q[0] <= t_end_i;
    end
    for (int s = 1; s < 4; s++) begin
      if (load[s]) begin
        t0_q[s] <= t0_q[s-1];
        t1_q[s] <= t1_q[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Slab lanes: difference, product, scale and saturate
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] tn_q [NumAxes];
  logic signed [W-1:0] tf_q [NumAxes];

  for (genvar a = 0; a < NumAxes; a++) begin : g_axis
    logic signed [W:0]   dlo;
    logic signed [W:0]   dhi;
    logic signed [W:0]   dn_d;
    logic signed [W:0]   df_d;
    logic signed [W:0]   dn_q;
    logic signed [W:0]   df_q;
    logic signed [W-1:0] k_q;
    logic signed [PW-1:0] pn_d;
    logic signed [PW-1:0] pf_d;
    logic signed [PW-1:0] pn_q;
    logic signed [PW-1:0] pf_q;
    logic signed [PW-1:0] sn;
    logic signed [PW-1:0] sf;
    logic [PW-W:0]        un;
    logic [PW-W:0]        uf;
    logic signed [W-1:0]  tn_d;
    logic signed [W-1:0]  tf_d;

    assign dlo = $signed({box_min_q[a][W-1], box_min_q[a]}) - $signed({org[a][W-1], org[a]});
    assign dhi = $signed({box_max_q[a][W-1], box_max_q[a]}) - $signed({org[a][W-1], org[a]});

    // A negative inverse direction swaps the near and far planes.
    assign dn_d = kin[a][W-1] ? dhi : dlo;
    assign df_d = kin[a][W-1] ? dlo : dhi;

    always_ff @(posedge clk_i) begin
      if (load[0]) begin
        dn_q <= dn_d;
        df_q <= df_d;
        k_q  <= kin[a];
      end
    end

    assign pn_d = dn_q * k_q;
    assign pf_d = df_q * k_q;

    always_ff @(posedge clk_i) begin
      if (load[1]) begin
        pn_q <= pn_d;
        pf_q <= pf_d;
      end
    end

    // The arithmetic shift rounds toward minus infinity.
    assign sn = pn_q >>> FRAC_BITS;
    assign sf = pf_q >>> FRAC_BITS;
    assign un = sn[PW-1:W-1];
    assign uf = sf[PW-1:W-1];

    always_comb begin
      if ((&un) || !(|un)) begin
        tn_d = sn[W-1:0];
      end else begin
        tn_d = sn[PW-1] ? CoordMin : CoordMax;
      end
      if ((&uf) || !(|uf)) begin
        tf_d = sf[W-1:0];
      end else begin
        tf_d = sf[PW-1] ? CoordMin : CoordMax;
      end
    end

    always_ff @(posedge clk_i) begin
      if (load[2]) begin
        tn_q[a] <= tn_d;
        tf_q[a] <= tf_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Merge x and y slabs
  // ---------------------------------------------------------------------------
  logic                miss4_q;
  logic signed [W-1:0] lo4_q;
  logic signed [W-1:0] hi4_q;
  logic signed [W-1:0] tnz4_q;
  logic signed [W-1:0] tfz4_q;

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      miss4_q <= (tn_q[0] > tf_q[1]) || (tn_q[1] > tf_q[0]);
      lo4_q   <= (tn_q[1] > tn_q[0]) ? tn_q[1] : tn_q[0];
      hi4_q   <= (tf_q[1] < tf_q[0]) ? tf_q[1] : tf_q[0];
      tnz4_q  <= tn_q[2];
      tfz4_q  <= tf_q[2];
    end
  end

  // ---------------------------------------------------------------------------
  // Merge z slab
  // ---------------------------------------------------------------------------
  logic                miss5_q;
  logic signed [W-1:0] lo5_q;
  logic signed [W-1:0] hi5_q;
  logic signed [W-1:0] t0_5_q;
  logic signed [W-1:0] t1_5_q;

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      miss5_q <= miss4_q || (lo4_q > tfz4_q) || (tnz4_q > hi4_q);
      lo5_q   <= (tnz4_q > lo4_q) ? tnz4_q : lo4_q;
      hi5_q   <= (tfz4_q < hi4_q) ? tfz4_q : hi4_q;
      t0_5_q  <= t0_q[3];
      t1_5_q  <= t1_q[3];
    end
  end

  // ---------------------------------------------------------------------------
  // Ray interval test, clamp and output register
  // ---------------------------------------------------------------------------
  logic                hit_d;
  logic signed [W-1:0] near_d;
  logic signed [W-1:0] far_d;
  logic                hit_q;
  logic signed [W-1:0] near_q;
  logic signed [W-1:0] far_q;

  always_comb begin
    hit_d  = !miss5_q && (lo5_q < t1_5_q) && (hi5_q > t0_5_q);
    near_d = CoordZero;
    far_d  = CoordZero;
    if (hit_d) begin
      near_d = (lo5_q < t0_5_q) ? t0_5_q : lo5_q;
      far_d  = (hi5_q > t1_5_q) ? t1_5_q : hi5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[5]) begin
      hit_q  <= hit_d;
      near_q <= near_d;
      far_q  <= far_d;
    end
  end

  assign out_valid_o = v_q[NStages-1];
  assign hit_o       = hit_q;
  assign t_near_o    = near_q;
  assign t_far_o     = far_q;

endmodule

`default_nettype wire

>>> sv/rbsi_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rbsi_checker
  import rbsi_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = DefCoordWidth
) (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   in_stall_o,
  input wire                   out_valid_o,
  input wire                   out_stall_i,
  input wire                   hit_o,
  input wire [COORD_WIDTH-1:0] t_near_o,
  input wire [COORD_WIDTH-1:0] t_far_o
);

  // A result held back by the receiver must not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o) && $stable(t_near_o)
      && $stable(t_far_o))
    else $error("stalled result changed");

  // The input is held off only when every stage is full and the output is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the pipeline could still move");

  // A miss carries zero parameters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> (t_near_o == '0) && (t_far_o == '0))
    else $error("miss with non-zero parameters");

endmodule

bind ray_box_slab_intersect rbsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbsi_checker (.*);

`default_nettype wire
